@@ hw/rtl/fpfa_pkg.sv @@
// Shared types and codes of the fixed-partition fit allocator.
package fpfa_pkg;

   localparam int MAX_PARTS = 4;
   localparam int SIZE_W    = 16;
   localparam int TOTAL_W   = 18;
   localparam int ID_W      = 8;

   typedef enum logic [2:0] {
      REG_FIT_POLICY  = 3'd0,
      REG_TOTAL_SIZE  = 3'd1,
      REG_PART_ZERO   = 3'd2,
      REG_PART_ONE    = 3'd3,
      REG_PART_TWO    = 3'd4,
      REG_PART_THREE  = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_WORST = 2'd2,
      POL_SPARE = 2'd3
   } policy_type;

   typedef enum logic [2:0] {
      ST_ALLOCATED  = 3'd0,
      ST_INTERNAL   = 3'd1,
      ST_EXTERNAL   = 3'd2,
      ST_TOO_LARGE  = 3'd3,
      ST_DELETED    = 3'd4,
      ST_NOT_FOUND  = 3'd5
   } status_type;

   localparam logic MODE_INSERT = 1'b0;

   typedef struct packed {
      logic [MAX_PARTS-1:0]             valid;
      logic [MAX_PARTS-1:0][SIZE_W-1:0] size;
      logic [TOTAL_W-1:0]               unused;
      logic [TOTAL_W-1:0]               sum;
   } lay_type;

   typedef struct packed {
      status_type         status;
      logic [1:0]         index;
      logic [TOTAL_W-1:0] frag;
      logic [TOTAL_W-1:0] free;
   } res_type;

endpackage

@@ hw/rtl/fpfa_layout.sv @@
// Partition layout: validity, sizes and leftover from the size registers.
module fpfa_layout #(
   parameter int PARTS = 4
) (
   input  logic                                                 clock,
   input  logic [fpfa_pkg::TOTAL_W-1:0]                         total_size,
   input  logic [fpfa_pkg::MAX_PARTS-1:0][fpfa_pkg::SIZE_W-1:0] part_size,
   output fpfa_pkg::lay_type                                    lay_ff
);

   fpfa_pkg::lay_type          lay_in;
   logic [fpfa_pkg::TOTAL_W-1:0] left;

   always_comb begin
      lay_in = '0;
      left   = total_size;
      for (int i = 0; i < fpfa_pkg::MAX_PARTS; i++) begin
         if (i < PARTS) begin
            if ({2'b00, part_size[i]} <= left) begin
               left           = left - {2'b00, part_size[i]};
               lay_in.valid[i] = 1'b1;
               lay_in.size[i]  = part_size[i];
            end
         end
      end
      lay_in.unused = left;
      lay_in.sum    = total_size - left;
   end

   always_ff @(posedge clock) begin
      lay_ff <= lay_in;
   end

endmodule

@@ hw/rtl/fpfa_core.sv @@
// Occupancy state, fit selection and reject classification.
module fpfa_core #(
   parameter int PARTS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rebuild,
   input  logic                          accept,
   input  logic [1:0]                    fit_policy,
   input  fpfa_pkg::lay_type             lay,
   input  logic                          mode,
   input  logic [fpfa_pkg::ID_W-1:0]     process_id,
   input  logic [fpfa_pkg::SIZE_W-1:0]   process_size,
   output fpfa_pkg::res_type             res
);

   logic [fpfa_pkg::ID_W-1:0]   occ_id_ff   [PARTS];
   logic [fpfa_pkg::SIZE_W-1:0] occ_size_ff [PARTS];
   logic [fpfa_pkg::TOTAL_W-1:0] frag_ff;
   logic [fpfa_pkg::TOTAL_W-1:0] free_ff;

   logic                         found;
   logic [1:0]                   pick;
   logic [fpfa_pkg::SIZE_W-1:0]  pick_size;
   logic                         inner;
   logic                         del_found;
   logic [1:0]                   del_idx;
   logic [fpfa_pkg::SIZE_W-1:0]  del_occ;
   logic [fpfa_pkg::SIZE_W-1:0]  del_part;
   logic [fpfa_pkg::SIZE_W-1:0]  slack;
   logic                         do_alloc;
   logic                         do_delete;

   always_comb begin
      found     = 1'b0;
      pick      = '0;
      pick_size = '0;
      inner     = 1'b0;
      del_found = 1'b0;
      del_idx   = '0;
      del_occ   = '0;
      del_part  = '0;
      for (int i = 0; i < PARTS; i++) begin
         if (lay.valid[i] && occ_id_ff[i] == '0 && lay.size[i] >= process_size) begin
            if (!found) begin
               found     = 1'b1;
               pick      = 2'(i);
               pick_size = lay.size[i];
            end else if ((fit_policy == fpfa_pkg::POL_BEST && lay.size[i] < pick_size) ||
                         (fit_policy == fpfa_pkg::POL_WORST && lay.size[i] > pick_size)) begin
               pick      = 2'(i);
               pick_size = lay.size[i];
            end
         end
         if (occ_id_ff[i] != '0 && lay.size[i] >= occ_size_ff[i] &&
             (lay.size[i] - occ_size_ff[i]) >= process_size) begin
            inner = 1'b1;
         end
         if (!del_found && occ_id_ff[i] == process_id) begin
            del_found = 1'b1;
            del_idx   = 2'(i);
            del_occ   = occ_size_ff[i];
            del_part  = lay.size[i];
         end
      end
   end

   always_comb begin
      do_alloc   = 1'b0;
      do_delete  = 1'b0;
      slack      = del_part - del_occ;
      res.status = fpfa_pkg::ST_NOT_FOUND;
      res.index  = '0;
      res.frag   = frag_ff;
      res.free   = free_ff;
      if (process_id != '0) begin
         if (mode == fpfa_pkg::MODE_INSERT) begin
            if (found) begin
               do_alloc   = 1'b1;
               res.status = fpfa_pkg::ST_ALLOCATED;
               res.index  = pick;
               res.frag   = frag_ff + {2'b00, pick_size - process_size};
               res.free   = free_ff - {2'b00, process_size};
            end else if (inner) begin
               res.status = fpfa_pkg::ST_INTERNAL;
            end else if ({2'b00, process_size} <= free_ff) begin
               res.status = fpfa_pkg::ST_EXTERNAL;
            end else begin
               res.status = fpfa_pkg::ST_TOO_LARGE;
            end
         end else if (del_found) begin
            do_delete  = 1'b1;
            res.status = fpfa_pkg::ST_DELETED;
            res.index  = del_idx;
            res.frag   = frag_ff - {2'b00, slack};
            res.free   = free_ff + {2'b00, del_occ};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PARTS; i++) begin
            occ_id_ff[i] <= '0;
         end
         frag_ff <= '0;
         free_ff <= '0;
      end else if (rebuild) begin
         for (int i = 0; i < PARTS; i++) begin
            occ_id_ff[i] <= '0;
         end
         frag_ff <= '0;
         free_ff <= lay.sum;
      end else if (accept) begin
         for (int i = 0; i < PARTS; i++) begin
            if (do_alloc && pick == 2'(i)) begin
               occ_id_ff[i] <= process_id;
            end else if (do_delete && del_idx == 2'(i)) begin
               occ_id_ff[i] <= '0;
            end
         end
         frag_ff <= res.frag;
         free_ff <= res.free;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PARTS; i++) begin
         if (accept && do_alloc && pick == 2'(i)) begin
            occ_size_ff[i] <= process_size;
         end
      end
   end

   property p_alloc_fits;
      @(posedge clock) disable iff (reset)
         accept && do_alloc |-> lay.valid[pick] && pick_size >= process_size;
   endproperty
   a_alloc_fits: assert property (p_alloc_fits) else $error("allocated partition too small");

   property p_reject_has_no_fit;
      @(posedge clock) disable iff (reset)
         accept && mode == fpfa_pkg::MODE_INSERT && process_id != '0 && !do_alloc
         |-> !found;
   endproperty
   a_reject_has_no_fit: assert property (p_reject_has_no_fit) else $error("fit rejected");

   property p_rebuild_clears_frag;
      @(posedge clock) disable iff (reset)
         rebuild |=> frag_ff == '0;
   endproperty
   a_rebuild_clears_frag: assert property (p_rebuild_clears_frag) else $error("frag kept");

endmodule

@@ hw/rtl/fixed_partition_fit_allocator.sv @@
// Fixed-partition fit allocator top level: register file, handshake and result register.
// Takes one insert or delete word per clock and returns its result word in the next
// cycle from a result register, so input and output run at full rate while rsp_ready
// stays high outside a rebuild; a stalled result holds the input back only when the
// result register is full. Each csr write to a defined register rebuilds the partition
// table: all partitions become empty and the input channel is held off while the
// registered layout (partition validity, sizes, leftover) settles and the free total is
// reloaded. The same rebuild runs after reset. Writes to undefined indices are dropped.
module fixed_partition_fit_allocator #(
   parameter int PARTS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic [fpfa_pkg::ID_W-1:0]       req_process_id,
   input  logic [fpfa_pkg::SIZE_W-1:0]     req_process_size,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_status,
   output logic [1:0]                      rsp_partition_index,
   output logic [fpfa_pkg::TOTAL_W-1:0]    rsp_internal_fragmentation,
   output logic [fpfa_pkg::TOTAL_W-1:0]    rsp_free_space,
   output logic [fpfa_pkg::TOTAL_W-1:0]    rsp_unused_space,
   input  logic                            csr_write,
   input  logic [2:0]                      csr_index,
   input  logic [fpfa_pkg::TOTAL_W-1:0]    csr_wdata
);

   logic [1:0]                                           fit_policy_ff;
   logic [fpfa_pkg::TOTAL_W-1:0]                         total_size_ff;
   logic [fpfa_pkg::MAX_PARTS-1:0][fpfa_pkg::SIZE_W-1:0] part_size_ff;
   logic [1:0]                                           pend_ff;
   logic [1:0]                                           pend_in;
   logic                                                 rsp_valid_ff;
   logic                                                 rsp_valid_in;
   fpfa_pkg::res_type                                    res_ff;
   logic [fpfa_pkg::TOTAL_W-1:0]                         unused_ff;
   logic                                                 cfg_hit;
   logic                                                 accept;
   fpfa_pkg::lay_type                                    lay;
   fpfa_pkg::res_type                                    res;

   always_comb begin
      unique case (csr_index)
         fpfa_pkg::REG_FIT_POLICY, fpfa_pkg::REG_TOTAL_SIZE, fpfa_pkg::REG_PART_ZERO,
         fpfa_pkg::REG_PART_ONE, fpfa_pkg::REG_PART_TWO, fpfa_pkg::REG_PART_THREE: begin
            cfg_hit = csr_write;
         end
         default: begin
            cfg_hit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff <= fpfa_pkg::POL_BEST;
         total_size_ff <= '0;
         part_size_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            fpfa_pkg::REG_FIT_POLICY: fit_policy_ff   <= csr_wdata[1:0];
            fpfa_pkg::REG_TOTAL_SIZE: total_size_ff   <= csr_wdata;
            fpfa_pkg::REG_PART_ZERO:  part_size_ff[0] <= csr_wdata[fpfa_pkg::SIZE_W-1:0];
            fpfa_pkg::REG_PART_ONE:   part_size_ff[1] <= csr_wdata[fpfa_pkg::SIZE_W-1:0];
            fpfa_pkg::REG_PART_TWO:   part_size_ff[2] <= csr_wdata[fpfa_pkg::SIZE_W-1:0];
            fpfa_pkg::REG_PART_THREE: part_size_ff[3] <= csr_wdata[fpfa_pkg::SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign pend_in      = cfg_hit ? 2'b11 : {1'b0, pend_ff[1]};
   assign req_ready    = (pend_ff == 2'b00) && (!rsp_valid_ff || rsp_ready);
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 2'b11;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff    <= res;
         unused_ff <= lay.unused;
      end
   end

   fpfa_layout #(
      .PARTS(PARTS)
   ) u_layout (
      .clock      (clock),
      .total_size (total_size_ff),
      .part_size  (part_size_ff),
      .lay_ff     (lay)
   );

   fpfa_core #(
      .PARTS(PARTS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .rebuild      (pend_ff != 2'b00),
      .accept       (accept),
      .fit_policy   (fit_policy_ff),
      .lay          (lay),
      .mode         (req_mode),
      .process_id   (req_process_id),
      .process_size (req_process_size),
      .res          (res)
   );

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_status                 = res_ff.status;
   assign rsp_partition_index        = res_ff.index;
   assign rsp_internal_fragmentation = res_ff.frag;
   assign rsp_free_space             = res_ff.free;
   assign rsp_unused_space           = unused_ff;

   property p_no_accept_in_rebuild;
      @(posedge clock) disable iff (reset)
         pend_ff != 2'b00 |-> !req_ready;
   endproperty
   a_no_accept_in_rebuild: assert property (p_no_accept_in_rebuild) else $error("word in rebuild");

   property p_write_stalls_input;
      @(posedge clock) disable iff (reset)
         cfg_hit |=> !req_ready ##1 !req_ready;
   endproperty
   a_write_stalls_input: assert property (p_write_stalls_input) else $error("no rebuild stall");

   property p_accept_gives_result;
      @(posedge clock) disable iff (reset)
         accept |=> rsp_valid_ff;
   endproperty
   a_accept_gives_result: assert property (p_accept_gives_result) else $error("result lost");

endmodule

@@ tb/tb_fixed_partition_fit_allocator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the fixed-partition fit allocator.
module tb_fixed_partition_fit_allocator;

   localparam int         NPARTS      = fpfa_pkg::MAX_PARTS;
   localparam int         PHASES      = 7;
   localparam int         PHASE_WORDS = 118;
   localparam int         SETTLE      = 4;
   localparam int         CYCLE_LIMIT = 500000;
   localparam logic       MODE_DELETE = 1'b1;
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   typedef struct packed {
      fpfa_pkg::status_type         status;
      logic [1:0]                   index;
      logic [fpfa_pkg::TOTAL_W-1:0] frag;
      logic [fpfa_pkg::TOTAL_W-1:0] vacant;
      logic [fpfa_pkg::TOTAL_W-1:0] spare;
   } alloc_result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_mode;
   logic [fpfa_pkg::ID_W-1:0]     req_process_id;
   logic [fpfa_pkg::SIZE_W-1:0]   req_process_size;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [2:0]                    rsp_status;
   logic [1:0]                    rsp_partition_index;
   logic [fpfa_pkg::TOTAL_W-1:0]  rsp_internal_fragmentation;
   logic [fpfa_pkg::TOTAL_W-1:0]  rsp_free_space;
   logic [fpfa_pkg::TOTAL_W-1:0]  rsp_unused_space;
   logic                          csr_write;
   logic [2:0]                    csr_index;
   logic [fpfa_pkg::TOTAL_W-1:0]  csr_wdata;

   fpfa_pkg::policy_type          fit_pol;
   logic [fpfa_pkg::TOTAL_W-1:0]  total_units;
   logic [fpfa_pkg::SIZE_W-1:0]   part_req [NPARTS];
   logic [fpfa_pkg::SIZE_W-1:0]   part_units [NPARTS];
   logic                          part_ok [NPARTS];
   logic [fpfa_pkg::TOTAL_W-1:0]  spare_units;
   logic [fpfa_pkg::TOTAL_W-1:0]  frag_units;
   logic [fpfa_pkg::TOTAL_W-1:0]  free_units;
   logic [fpfa_pkg::ID_W-1:0]     holder_id [NPARTS];
   logic [fpfa_pkg::SIZE_W-1:0]   holder_size [NPARTS];

   alloc_result_type    outcomes_due [$];
   int                  mismatch_count = 0;
   bit                  sender_gaps = 1'b0;
   bit                  receiver_stalls = 1'b0;

   fixed_partition_fit_allocator #(.PARTS(NPARTS)) DUT (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_ready                  (req_ready),
      .req_mode                   (req_mode),
      .req_process_id             (req_process_id),
      .req_process_size           (req_process_size),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_status                 (rsp_status),
      .rsp_partition_index        (rsp_partition_index),
      .rsp_internal_fragmentation (rsp_internal_fragmentation),
      .rsp_free_space             (rsp_free_space),
      .rsp_unused_space           (rsp_unused_space),
      .csr_write                  (csr_write),
      .csr_index                  (csr_index),
      .csr_wdata                  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic void rebuild_table();
      logic [fpfa_pkg::TOTAL_W-1:0] left;
      logic [fpfa_pkg::TOTAL_W-1:0] sum;
      left = total_units;
      sum  = '0;
      for (int i = 0; i < NPARTS; i++) begin
         holder_id[i]   = '0;
         holder_size[i] = '0;
         if ({2'b00, part_req[i]} <= left) begin
            left          = left - part_req[i];
            sum           = sum + part_req[i];
            part_units[i] = part_req[i];
            part_ok[i]    = 1'b1;
         end else begin
            part_units[i] = '0;
            part_ok[i]    = 1'b0;
         end
      end
      spare_units = left;
      frag_units  = '0;
      free_units  = sum;
   endfunction

   function automatic alloc_result_type alloc_outcome(
      input logic mode, input logic [fpfa_pkg::ID_W-1:0] id,
      input logic [fpfa_pkg::SIZE_W-1:0] units);
      alloc_result_type res;
      int               pick;
      logic             inner;
      logic             found;
      res.status = fpfa_pkg::ST_NOT_FOUND;
      res.index  = '0;
      if (mode == fpfa_pkg::MODE_INSERT) begin
         if (id != '0) begin
            pick = -1;
            for (int i = 0; i < NPARTS; i++) begin
               if (part_ok[i] && holder_id[i] == '0 && part_units[i] >= units) begin
                  if (pick < 0) pick = i;
                  else if (fit_pol == fpfa_pkg::POL_BEST &&
                           part_units[i] < part_units[pick]) pick = i;
                  else if (fit_pol == fpfa_pkg::POL_WORST &&
                           part_units[i] > part_units[pick]) pick = i;
               end
            end
            if (pick >= 0) begin
               holder_id[pick]   = id;
               holder_size[pick] = units;
               frag_units = frag_units + (part_units[pick] - units);
               free_units = free_units - units;
               res.status = fpfa_pkg::ST_ALLOCATED;
               res.index  = 2'(pick);
            end else begin
               inner = 1'b0;
               for (int i = 0; i < NPARTS; i++) begin
                  if (holder_id[i] != '0 && part_units[i] >= holder_size[i] &&
                      part_units[i] - holder_size[i] >= units)
                     inner = 1'b1;
               end
               if (inner) res.status = fpfa_pkg::ST_INTERNAL;
               else if ({2'b00, units} <= free_units) res.status = fpfa_pkg::ST_EXTERNAL;
               else res.status = fpfa_pkg::ST_TOO_LARGE;
            end
         end
      end else if (id != '0) begin
         found = 1'b0;
         for (int i = 0; i < NPARTS; i++) begin
            if (!found && holder_id[i] == id) begin
               found        = 1'b1;
               holder_id[i] = '0;
               free_units   = free_units + holder_size[i];
               frag_units   = frag_units - (part_units[i] - holder_size[i]);
               res.status   = fpfa_pkg::ST_DELETED;
               res.index    = 2'(i);
            end
         end
      end
      res.frag   = frag_units;
      res.vacant = free_units;
      res.spare  = spare_units;
      return res;
   endfunction

   task automatic write_reg(input logic [2:0] idx,
                            input logic [fpfa_pkg::TOTAL_W-1:0] value);
      logic mapped;
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      mapped = 1'b1;
      case (idx)
         fpfa_pkg::REG_FIT_POLICY: fit_pol     = fpfa_pkg::policy_type'(value[1:0]);
         fpfa_pkg::REG_TOTAL_SIZE: total_units = value;
         fpfa_pkg::REG_PART_ZERO:  part_req[0] = value[fpfa_pkg::SIZE_W-1:0];
         fpfa_pkg::REG_PART_ONE:   part_req[1] = value[fpfa_pkg::SIZE_W-1:0];
         fpfa_pkg::REG_PART_TWO:   part_req[2] = value[fpfa_pkg::SIZE_W-1:0];
         fpfa_pkg::REG_PART_THREE: part_req[3] = value[fpfa_pkg::SIZE_W-1:0];
         default:                  mapped = 1'b0;
      endcase
      if (mapped) rebuild_table();
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_layout(input fpfa_pkg::policy_type pol,
                              input logic [fpfa_pkg::TOTAL_W-1:0] total,
                              input logic [fpfa_pkg::SIZE_W-1:0] s0,
                              input logic [fpfa_pkg::SIZE_W-1:0] s1,
                              input logic [fpfa_pkg::SIZE_W-1:0] s2,
                              input logic [fpfa_pkg::SIZE_W-1:0] s3);
      write_reg(fpfa_pkg::REG_FIT_POLICY, {16'($urandom()), pol});
      write_reg(fpfa_pkg::REG_TOTAL_SIZE, total);
      write_reg(fpfa_pkg::REG_PART_ZERO, {2'($urandom()), s0});
      write_reg(fpfa_pkg::REG_PART_ONE, {2'($urandom()), s1});
      write_reg(fpfa_pkg::REG_PART_TWO, {2'($urandom()), s2});
      write_reg(fpfa_pkg::REG_PART_THREE, {2'($urandom()), s3});
   endtask

   task automatic send_word(input logic mode, input logic [fpfa_pkg::ID_W-1:0] id,
                            input logic [fpfa_pkg::SIZE_W-1:0] units);
      int               gap;
      alloc_result_type due;
      gap = (sender_gaps && $urandom_range(0, 9) < 4) ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_process_id   <= id;
      req_process_size <= units;
      do begin
         @(posedge clock);
      end while (req_ready !== 1'b1);
      due = alloc_outcome(mode, id, units);
      outcomes_due.insert(outcomes_due.size(), due);
   endtask

   task automatic settle_allocator();
      req_valid <= 1'b0;
      while (outcomes_due.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_word(fpfa_pkg::MODE_INSERT, 8'd1, 16'd1);
      send_word(MODE_DELETE, 8'd1, 16'd1);
   endtask

   task automatic test_fit_policies();
      fpfa_pkg::policy_type order [4] = '{fpfa_pkg::POL_FIRST, fpfa_pkg::POL_BEST,
                                          fpfa_pkg::POL_WORST, fpfa_pkg::POL_SPARE};
      settle_allocator();
      load_layout(fpfa_pkg::POL_FIRST, 18'd1000, 16'd100, 16'd300, 16'd200, 16'd500);
      foreach (order[p]) begin
         settle_allocator();
         write_reg(fpfa_pkg::REG_FIT_POLICY, {16'd0, order[p]});
         send_word(fpfa_pkg::MODE_INSERT, 8'd1, 16'd90);
         send_word(fpfa_pkg::MODE_INSERT, 8'd2, 16'd150);
         send_word(fpfa_pkg::MODE_INSERT, 8'd3, 16'd400);
      end
   endtask

   task automatic test_corner_cases();
      settle_allocator();
      load_layout(fpfa_pkg::POL_FIRST, 18'h3FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(fpfa_pkg::MODE_INSERT, 8'd255, 16'hFFFF);
      send_word(fpfa_pkg::MODE_INSERT, 8'd0, 16'd5);
      send_word(MODE_DELETE, 8'd0, 16'd5);
      send_word(MODE_DELETE, 8'd77, 16'd1);
      send_word(fpfa_pkg::MODE_INSERT, 8'd255, 16'd1);
      send_word(fpfa_pkg::MODE_INSERT, 8'd9, 16'hFFFF);
      send_word(fpfa_pkg::MODE_INSERT, 8'd10, 16'd40000);
      send_word(fpfa_pkg::MODE_INSERT, 8'd11, 16'd30000);
      send_word(MODE_DELETE, 8'd255, 16'hFFFF);
      settle_allocator();
      load_layout(fpfa_pkg::POL_BEST, 18'd300, 16'd100, 16'd100, 16'd100, 16'd0);
      send_word(fpfa_pkg::MODE_INSERT, 8'd1, 16'd60);
      send_word(fpfa_pkg::MODE_INSERT, 8'd2, 16'd60);
      send_word(fpfa_pkg::MODE_INSERT, 8'd3, 16'd60);
      send_word(fpfa_pkg::MODE_INSERT, 8'd4, 16'd50);
   endtask

   task automatic test_random_traffic();
      int                           kind;
      int                           roll;
      int                           slot;
      logic [fpfa_pkg::SIZE_W-1:0]  sizes [NPARTS];
      logic [fpfa_pkg::TOTAL_W-1:0] sum;
      logic [fpfa_pkg::TOTAL_W-1:0] total;
      logic [fpfa_pkg::SIZE_W-1:0]  base;
      logic [fpfa_pkg::SIZE_W-1:0]  units;
      logic [fpfa_pkg::ID_W-1:0]    id;
      logic                         mode;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle_allocator();
         sender_gaps     = (phase == 1) || (phase > 1 && $urandom_range(0, 3) != 0);
         receiver_stalls = (phase == 1) || (phase > 1 && $urandom_range(0, 3) != 0);
         kind = (phase == 0) ? 0 : $urandom_range(0, 5);
         sum  = '0;
         for (int i = 0; i < NPARTS; i++) begin
            sizes[i] = (kind >= 4) ? 16'($urandom()) : 16'($urandom_range(0, 300));
            sum      = sum + sizes[i];
         end
         case (kind)
            3:       total = 18'($urandom_range(0, sum));
            4:       total = $urandom_range(0, 1) ? '1 : 18'($urandom());
            5:       total = '0;
            default: total = sum + 18'($urandom_range(0, 50));
         endcase
         load_layout(fpfa_pkg::policy_type'($urandom_range(0, 3)), total,
                     sizes[0], sizes[1], sizes[2], sizes[3]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 39) == 0) settle_allocator();
            if (phase == 3 && n == PHASE_WORDS / 2) begin
               settle_allocator();
               write_reg(REG_UNMAPPED, 18'($urandom()));
            end
            mode = ($urandom_range(0, 99) < 55) ? fpfa_pkg::MODE_INSERT : MODE_DELETE;
            slot = $urandom_range(0, NPARTS - 1);
            base = (part_units[slot] == '0) ? 16'd1 : part_units[slot];
            roll = $urandom_range(0, 99);
            if (roll < 50) units = 16'($urandom_range(1, base));
            else if (roll < 65) units = base;
            else if (roll < 80) units = 16'($urandom_range(1, 8));
            else if (roll < 90) units = (base == 16'hFFFF) ? base : base + 16'd1;
            else units = 16'($urandom_range(1, 65535));
            id   = 8'($urandom_range(1, 6));
            roll = $urandom_range(0, 99);
            if (roll < 5) id = '0;
            else if (roll < 20) id = 8'($urandom_range(1, 255));
            else if (mode == MODE_DELETE && roll < 75) begin
               for (int k = 0; k < NPARTS; k++) begin
                  if (holder_id[(slot + k) % NPARTS] != '0) id = holder_id[(slot + k) % NPARTS];
               end
            end
            send_word(mode, id, units);
         end
      end
   endtask

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) stall_left--;
         else if (receiver_stalls && $urandom_range(0, 4) == 0) stall_left = idle_span();
         rsp_ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin : result_checker
      alloc_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (outcomes_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: status %0d index %0d frag %0d free %0d unused %0d",
                        rsp_status, rsp_partition_index, rsp_internal_fragmentation,
                        rsp_free_space, rsp_unused_space);
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_status !== want.status || rsp_partition_index !== want.index ||
                rsp_internal_fragmentation !== want.frag || rsp_free_space !== want.vacant ||
                rsp_unused_space !== want.spare) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: status %0d/%0d index %0d/%0d frag %0d/%0d",
                            " free %0d/%0d unused %0d/%0d (expected/actual)"},
                           want.status, rsp_status, want.index, rsp_partition_index,
                           want.frag, rsp_internal_fragmentation, want.vacant, rsp_free_space,
                           want.spare, rsp_unused_space);
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("fixed_partition_fit_allocator regression: fail");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_mode         <= fpfa_pkg::MODE_INSERT;
      req_process_id   <= '0;
      req_process_size <= '0;
      csr_write        <= 1'b0;
      csr_index        <= fpfa_pkg::REG_FIT_POLICY;
      csr_wdata        <= '0;
      fit_pol     = fpfa_pkg::POL_BEST;
      total_units = '0;
      for (int i = 0; i < NPARTS; i++) part_req[i] = '0;
      rebuild_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_fit_policies();
      test_corner_cases();
      test_random_traffic();
      settle_allocator();
      mismatch_count += outcomes_due.size();
      if (mismatch_count == 0)
         $display("fixed_partition_fit_allocator regression: pass");
      else
         $display("fixed_partition_fit_allocator regression: fail");
      $finish;
   end

endmodule
